// File: rtl/point_to_occupancy_grid_update_unit_assert.svh
// ---------------------------------------------------------------------------
// Occupancy grid update unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef POINT_TO_OCCUPANCY_GRID_UPDATE_UNIT_ASSERT_SVH
`define POINT_TO_OCCUPANCY_GRID_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define OGU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define OGU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/ogu_pkg.sv
// ---------------------------------------------------------------------------
// Occupancy grid update package
// Shared sizes, codes and the front-to-back command record.
// ---------------------------------------------------------------------------
package ogu_pkg;

  localparam int MAX_COLS       = 64;
  localparam int MAX_ROWS       = 64;
  localparam int INFLATE_RADIUS = 3;
  localparam int COL_W          = $clog2(MAX_COLS);
  localparam int ROW_W          = $clog2(MAX_ROWS);
  localparam int ADDR_W         = COL_W + ROW_W;
  localparam int DIM_W          = 7;
  localparam int VAL_W          = 7;
  localparam int OFF_W          = $clog2(2 * INFLATE_RADIUS + 1);
  localparam int MAG_W          = 16;
  localparam int CS_W           = 12;
  localparam int BIT_CNT_W      = $clog2(MAG_W);
  localparam logic [VAL_W-1:0] CELL_FULL = 7'd100;

  // request codes
  localparam logic [1:0] REQ_POINT = 2'd0;
  localparam logic [1:0] REQ_DECAY = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_CELL_SIZE  = 3'd2,
    REG_Z_LOW      = 3'd3,
    REG_Z_HIGH     = 3'd4,
    REG_MAP_WIDTH  = 3'd5,
    REG_MAP_HEIGHT = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OUTSIDE = 3'd0,
    ST_FREE    = 3'd1,
    ST_OCC     = 3'd2,
    ST_DECAY   = 3'd3,
    ST_READ    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_FREE,
    CMD_OCC,
    CMD_DECAY,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [DIM_W-1:0] used_w;
    logic [DIM_W-1:0] used_h;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [CS_W-1:0]    cell_size;
    logic signed [15:0] z_low;
    logic signed [15:0] z_high;
    logic [DIM_W-1:0]   used_w;
    logic [DIM_W-1:0]   used_h;
  } cfg_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_EVAL,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_START,
    B_INFL,
    B_DECAY,
    B_DRAIN,
    B_RDWAIT,
    B_DONE
  } be_state_t;

  // offset pair lies inside the inflation circle
  function automatic logic in_circle(logic [OFF_W-1:0] i, logic [OFF_W-1:0] j);
    int di;
    int dj;
    di = int'(i) - INFLATE_RADIUS;
    dj = int'(j) - INFLATE_RADIUS;
    return (di * di + dj * dj) <= INFLATE_RADIUS * INFLATE_RADIUS;
  endfunction

endpackage

// File: rtl/point_to_occupancy_grid_update_unit.sv
// ---------------------------------------------------------------------------
// Point to occupancy grid update unit
// Marks, inflates, decays and reads a 64 x 64 grid of 0..100 cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per beat: point update, end-of-frame
//   decay or cell read. Result channel (out_*): exactly one result beat per
//   request, in request order. Configuration via an APB-style port, one
//   register per word at byte address 4*index; pready is always high.
// Flow:
//   An occupied point walks a 7 x 7 inflation window through the single
//   memory read port, and a decay sweeps the 4096-cell memory. The front
//   end maps a point in its 16-step divider; a two-entry command queue
//   lets it map the next point while the back end works.
// Reset:
//   Registers return to their defaults; a clearing pass zeroes the grid,
//   during which in_ready stays low.
// Stall:
//   A stalled receiver holds the result register; the back end finishes the
//   next command and waits, then the queue fills and in_ready drops.
// ---------------------------------------------------------------------------
module point_to_occupancy_grid_update_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic signed [15:0] in_point_z,
  input  logic [5:0]         in_read_col,
  input  logic [5:0]         in_read_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [6:0]         out_cell_value,
  output logic [5:0]         out_cell_col,
  output logic [5:0]         out_cell_row,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [15:0] origin_x_r, origin_y_r, z_low_r, z_high_r;
  logic [11:0]        cell_size_r;
  logic [6:0]         map_width_r, map_height_r;

  ogu_pkg::cfg_t      cfg;
  ogu_pkg::cmd_t      push_data, pop_data;
  ogu_pkg::reg_idx_t  reg_idx;
  logic               cfg_wr, q_push, q_pop, q_full, q_empty, clear_done;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = ogu_pkg::reg_idx_t'(paddr[4:2]);

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= -16'sd2000;
      origin_y_r   <= -16'sd2000;
      cell_size_r  <= 12'd100;
      z_low_r      <= 16'sd20;
      z_high_r     <= 16'sd500;
      map_width_r  <= 7'd40;
      map_height_r <= 7'd40;
    end else if (cfg_wr) begin
      case (reg_idx)
        ogu_pkg::REG_ORIGIN_X:   origin_x_r   <= pwdata[15:0];
        ogu_pkg::REG_ORIGIN_Y:   origin_y_r   <= pwdata[15:0];
        ogu_pkg::REG_CELL_SIZE:  cell_size_r  <= pwdata[11:0];
        ogu_pkg::REG_Z_LOW:      z_low_r      <= pwdata[15:0];
        ogu_pkg::REG_Z_HIGH:     z_high_r     <= pwdata[15:0];
        ogu_pkg::REG_MAP_WIDTH:  map_width_r  <= pwdata[6:0];
        ogu_pkg::REG_MAP_HEIGHT: map_height_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_idx)
      ogu_pkg::REG_ORIGIN_X:   prdata = {16'b0, origin_x_r};
      ogu_pkg::REG_ORIGIN_Y:   prdata = {16'b0, origin_y_r};
      ogu_pkg::REG_CELL_SIZE:  prdata = {20'b0, cell_size_r};
      ogu_pkg::REG_Z_LOW:      prdata = {16'b0, z_low_r};
      ogu_pkg::REG_Z_HIGH:     prdata = {16'b0, z_high_r};
      ogu_pkg::REG_MAP_WIDTH:  prdata = {25'b0, map_width_r};
      ogu_pkg::REG_MAP_HEIGHT: prdata = {25'b0, map_height_r};
      default:                 prdata = '0;
    endcase
  end

  // clamp map size to the grid
  always_comb begin
    cfg.origin_x  = origin_x_r;
    cfg.origin_y  = origin_y_r;
    cfg.cell_size = cell_size_r;
    cfg.z_low     = z_low_r;
    cfg.z_high    = z_high_r;
    cfg.used_w    = (map_width_r > 7'(ogu_pkg::MAX_COLS)) ? 7'(ogu_pkg::MAX_COLS)
                                                         : map_width_r;
    cfg.used_h    = (map_height_r > 7'(ogu_pkg::MAX_ROWS)) ? 7'(ogu_pkg::MAX_ROWS)
                                                          : map_height_r;
  end

  ogu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_point_z  (in_point_z),
    .in_read_col (in_read_col),
    .in_read_row (in_read_row),
    .cfg         (cfg),
    .enable      (clear_done),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  ogu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ogu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .clear_done     (clear_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_cell_value (out_cell_value),
    .out_cell_col   (out_cell_col),
    .out_cell_row   (out_cell_row)
  );

endmodule

// File: rtl/ogu_front.sv
// ---------------------------------------------------------------------------
// Occupancy grid front end
// Accepts requests, maps points to cells with a bit-serial divider and
// pushes a classified command into the queue.
// ---------------------------------------------------------------------------
module ogu_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_req_type,
  input  logic signed [15:0]      in_point_x,
  input  logic signed [15:0]      in_point_y,
  input  logic signed [15:0]      in_point_z,
  input  logic [5:0]              in_read_col,
  input  logic [5:0]              in_read_row,
  input  ogu_pkg::cfg_t           cfg,
  input  logic                    enable,
  input  logic                    q_full,
  output logic                    q_push,
  output ogu_pkg::cmd_t           q_data
);

  ogu_pkg::fe_state_t state_r, state_nxt;
  ogu_pkg::cmd_kind_t kind_r, kind_nxt;
  logic [ogu_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [ogu_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic                          occ_r, occ_nxt;
  logic                          negx_r, negx_nxt, negy_r, negy_nxt;
  logic [ogu_pkg::MAG_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic [ogu_pkg::CS_W-1:0]      rx_r, rx_nxt, ry_r, ry_nxt;
  logic [ogu_pkg::CS_W-1:0]      cs_r, cs_nxt;
  logic [ogu_pkg::BIT_CNT_W-1:0] cnt_r, cnt_nxt;

  logic                 accept;
  logic signed [16:0]   diff_x, diff_y;
  logic [16:0]          abs_x, abs_y;
  logic [ogu_pkg::CS_W:0] tx, ty;
  logic                 gex, gey;
  logic                 col_ok, row_ok;

  assign in_ready = (state_r == ogu_pkg::FE_IDLE) && enable;
  assign accept   = in_valid && in_ready;

  // signed offsets from the origin and their magnitudes
  assign diff_x = {in_point_x[15], in_point_x} - {cfg.origin_x[15], cfg.origin_x};
  assign diff_y = {in_point_y[15], in_point_y} - {cfg.origin_y[15], cfg.origin_y};
  assign abs_x  = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
  assign abs_y  = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);

  // one restoring division step per cycle for both axes
  assign tx  = {rx_r, dx_r[ogu_pkg::MAG_W-1]};
  assign ty  = {ry_r, dy_r[ogu_pkg::MAG_W-1]};
  assign gex = tx >= {1'b0, cs_r};
  assign gey = ty >= {1'b0, cs_r};

  // quotient in range: truncation toward zero leaves small negatives at 0
  assign col_ok = (!negx_r || (dx_r == '0)) && (dx_r < {9'b0, cfg.used_w});
  assign row_ok = (!negy_r || (dy_r == '0)) && (dy_r < {9'b0, cfg.used_h});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ogu_pkg::FE_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == ogu_pkg::REQ_POINT) ? ogu_pkg::FE_DIV
                                                          : ogu_pkg::FE_PUSH;
        end
      end
      ogu_pkg::FE_DIV: begin
        if (cnt_r == ogu_pkg::BIT_CNT_W'(ogu_pkg::MAG_W - 1)) begin
          state_nxt = ogu_pkg::FE_EVAL;
        end
      end
      ogu_pkg::FE_EVAL: state_nxt = ogu_pkg::FE_PUSH;
      ogu_pkg::FE_PUSH: begin
        if (!q_full) begin
          state_nxt = ogu_pkg::FE_IDLE;
        end
      end
      default: state_nxt = ogu_pkg::FE_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_nxt = kind_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    occ_nxt  = occ_r;
    negx_nxt = negx_r;
    negy_nxt = negy_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    cs_nxt   = cs_r;
    cnt_nxt  = cnt_r;
    q_push   = 1'b0;
    case (state_r)
      ogu_pkg::FE_IDLE: begin
        if (accept) begin
          col_nxt = '0;
          row_nxt = '0;
          case (in_req_type)
            ogu_pkg::REQ_POINT: begin
              kind_nxt = ogu_pkg::CMD_NONE;
              occ_nxt  = (in_point_z > cfg.z_low) && (in_point_z < cfg.z_high);
              negx_nxt = diff_x[16];
              negy_nxt = diff_y[16];
              dx_nxt   = abs_x[ogu_pkg::MAG_W-1:0];
              dy_nxt   = abs_y[ogu_pkg::MAG_W-1:0];
              rx_nxt   = '0;
              ry_nxt   = '0;
              cs_nxt   = (cfg.cell_size == '0) ? ogu_pkg::CS_W'(1) : cfg.cell_size;
              cnt_nxt  = '0;
            end
            ogu_pkg::REQ_DECAY: kind_nxt = ogu_pkg::CMD_DECAY;
            ogu_pkg::REQ_READ: begin
              col_nxt  = in_read_col;
              row_nxt  = in_read_row;
              kind_nxt = (({1'b0, in_read_col} < cfg.used_w) &&
                          ({1'b0, in_read_row} < cfg.used_h)) ? ogu_pkg::CMD_READ
                                                             : ogu_pkg::CMD_NONE;
            end
            default: kind_nxt = ogu_pkg::CMD_NONE;
          endcase
        end
      end
      ogu_pkg::FE_DIV: begin
        rx_nxt  = gex ? ogu_pkg::CS_W'(tx - {1'b0, cs_r}) : tx[ogu_pkg::CS_W-1:0];
        ry_nxt  = gey ? ogu_pkg::CS_W'(ty - {1'b0, cs_r}) : ty[ogu_pkg::CS_W-1:0];
        dx_nxt  = {dx_r[ogu_pkg::MAG_W-2:0], gex};
        dy_nxt  = {dy_r[ogu_pkg::MAG_W-2:0], gey};
        cnt_nxt = cnt_r + 1'b1;
      end
      ogu_pkg::FE_EVAL: begin
        if (col_ok && row_ok) begin
          kind_nxt = occ_r ? ogu_pkg::CMD_OCC : ogu_pkg::CMD_FREE;
          col_nxt  = dx_r[ogu_pkg::COL_W-1:0];
          row_nxt  = dy_r[ogu_pkg::ROW_W-1:0];
        end else begin
          kind_nxt = ogu_pkg::CMD_NONE;
        end
      end
      ogu_pkg::FE_PUSH: q_push = !q_full;
      default: ;
    endcase
  end

  assign q_data.kind   = kind_r;
  assign q_data.col    = col_r;
  assign q_data.row    = row_r;
  assign q_data.used_w = cfg.used_w;
  assign q_data.used_h = cfg.used_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ogu_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r <= kind_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    occ_r  <= occ_nxt;
    negx_r <= negx_nxt;
    negy_r <= negy_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    cs_r   <= cs_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// File: rtl/ogu_queue.sv
// ---------------------------------------------------------------------------
// Occupancy grid command queue
// Two-entry FIFO of commands between the front and back ends.
// ---------------------------------------------------------------------------
module ogu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ogu_pkg::cmd_t push_data,
  input  logic          pop,
  output ogu_pkg::cmd_t pop_data,
  output logic          full,
  output logic          empty
);

  ogu_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = count_r == 2'd2;
  assign empty    = count_r == 2'd0;
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/ogu_back.sv
// ---------------------------------------------------------------------------
// Occupancy grid back end
// Holds the grid memory, clears it after reset and carries out mark,
// inflate, decay and read commands; drives the result register.
// ---------------------------------------------------------------------------
`include "point_to_occupancy_grid_update_unit_assert.svh"

module ogu_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  ogu_pkg::cmd_t              q_data,
  output logic                       q_pop,
  output logic                       clear_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [ogu_pkg::VAL_W-1:0]  out_cell_value,
  output logic [ogu_pkg::COL_W-1:0]  out_cell_col,
  output logic [ogu_pkg::ROW_W-1:0]  out_cell_row
);

  localparam int DEPTH = ogu_pkg::MAX_COLS * ogu_pkg::MAX_ROWS;
  localparam int RW    = ogu_pkg::ROW_W + 2;
  localparam int CW    = ogu_pkg::COL_W + 2;
  localparam logic [ogu_pkg::OFF_W-1:0] OFF_LAST =
    ogu_pkg::OFF_W'(2 * ogu_pkg::INFLATE_RADIUS);

  logic [ogu_pkg::VAL_W-1:0] mem [DEPTH];

  ogu_pkg::be_state_t state_r, state_nxt;
  ogu_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [ogu_pkg::ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ogu_pkg::OFF_W-1:0]  dr_r, dr_nxt, dc_r, dc_nxt;
  logic                       pv_r, pv_nxt;
  logic [ogu_pkg::ADDR_W-1:0] pa_r, pa_nxt;
  logic [ogu_pkg::VAL_W-1:0]  rd_data_r;

  ogu_pkg::status_t          res_status_r, res_status_nxt;
  logic [ogu_pkg::VAL_W-1:0] res_value_r, res_value_nxt;
  logic [ogu_pkg::COL_W-1:0] res_col_r, res_col_nxt;
  logic [ogu_pkg::ROW_W-1:0] res_row_r, res_row_nxt;

  logic                      out_valid_r, out_valid_nxt;
  ogu_pkg::status_t          out_status_r;
  logic [ogu_pkg::VAL_W-1:0] out_value_r;
  logic [ogu_pkg::COL_W-1:0] out_col_r;
  logic [ogu_pkg::ROW_W-1:0] out_row_r;
  logic                      out_load;

  logic                       mem_we, mem_re;
  logic [ogu_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [ogu_pkg::VAL_W-1:0]  mem_wdata, upd_val;

  logic signed [RW-1:0] nr;
  logic signed [CW-1:0] nc;
  logic                 off_ok, infl_last, out_free, in_scan;

  assign clear_done = state_r != ogu_pkg::B_CLEAR;
  assign out_free   = !out_valid_r || out_ready;
  assign in_scan    = (state_r == ogu_pkg::B_INFL) || (state_r == ogu_pkg::B_DECAY) ||
                      (state_r == ogu_pkg::B_DRAIN);

  // neighbor cell of the current inflation offset
  assign nr = $signed({2'b00, cmd_r.row}) + $signed({{(RW-ogu_pkg::OFF_W){1'b0}}, dr_r})
              - RW'(ogu_pkg::INFLATE_RADIUS);
  assign nc = $signed({2'b00, cmd_r.col}) + $signed({{(CW-ogu_pkg::OFF_W){1'b0}}, dc_r})
              - CW'(ogu_pkg::INFLATE_RADIUS);
  assign off_ok = ogu_pkg::in_circle(dr_r, dc_r) && !nr[RW-1] && !nc[CW-1] &&
                  (nr < $signed({1'b0, cmd_r.used_h})) &&
                  (nc < $signed({1'b0, cmd_r.used_w}));
  assign infl_last = (dr_r == OFF_LAST) && (dc_r == OFF_LAST);

  // read-modify-write update of the pending cell
  assign upd_val = (cmd_r.kind == ogu_pkg::CMD_DECAY) ? (rd_data_r >> 1) :
                   (rd_data_r < ogu_pkg::CELL_FULL) ? rd_data_r + 1'b1 : rd_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ogu_pkg::B_CLEAR: begin
        if (cnt_r == '1) state_nxt = ogu_pkg::B_IDLE;
      end
      ogu_pkg::B_IDLE: begin
        if (!q_empty) state_nxt = ogu_pkg::B_START;
      end
      ogu_pkg::B_START: begin
        case (cmd_r.kind)
          ogu_pkg::CMD_OCC:   state_nxt = ogu_pkg::B_INFL;
          ogu_pkg::CMD_DECAY: state_nxt = ogu_pkg::B_DECAY;
          ogu_pkg::CMD_READ:  state_nxt = ogu_pkg::B_RDWAIT;
          default:            state_nxt = ogu_pkg::B_DONE;
        endcase
      end
      ogu_pkg::B_INFL: begin
        if (infl_last) state_nxt = ogu_pkg::B_DRAIN;
      end
      ogu_pkg::B_DECAY: begin
        if (cnt_r == '1) state_nxt = ogu_pkg::B_DRAIN;
      end
      ogu_pkg::B_DRAIN:  state_nxt = ogu_pkg::B_DONE;
      ogu_pkg::B_RDWAIT: state_nxt = ogu_pkg::B_DONE;
      ogu_pkg::B_DONE: begin
        if (out_free) state_nxt = ogu_pkg::B_IDLE;
      end
      default: state_nxt = ogu_pkg::B_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_nxt        = cmd_r;
    cnt_nxt        = cnt_r;
    dr_nxt         = dr_r;
    dc_nxt         = dc_r;
    pv_nxt         = 1'b0;
    pa_nxt         = pa_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_col_nxt    = res_col_r;
    res_row_nxt    = res_row_r;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = {cmd_r.row, cmd_r.col};
    mem_we         = pv_r;
    mem_waddr      = pa_r;
    mem_wdata      = upd_val;
    case (state_r)
      ogu_pkg::B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
      end
      ogu_pkg::B_IDLE: begin
        q_pop   = !q_empty;
        cmd_nxt = q_data;
        cnt_nxt = '0;
        dr_nxt  = '0;
        dc_nxt  = '0;
      end
      ogu_pkg::B_START: begin
        res_col_nxt    = cmd_r.col;
        res_row_nxt    = cmd_r.row;
        res_value_nxt  = '0;
        case (cmd_r.kind)
          ogu_pkg::CMD_FREE: begin
            res_status_nxt = ogu_pkg::ST_FREE;
            mem_we         = 1'b1;
            mem_waddr      = {cmd_r.row, cmd_r.col};
            mem_wdata      = '0;
          end
          ogu_pkg::CMD_OCC: begin
            res_status_nxt = ogu_pkg::ST_OCC;
            res_value_nxt  = ogu_pkg::CELL_FULL;
            mem_we         = 1'b1;
            mem_waddr      = {cmd_r.row, cmd_r.col};
            mem_wdata      = ogu_pkg::CELL_FULL;
          end
          ogu_pkg::CMD_DECAY: res_status_nxt = ogu_pkg::ST_DECAY;
          ogu_pkg::CMD_READ: begin
            res_status_nxt = ogu_pkg::ST_READ;
            mem_re         = 1'b1;
          end
          default: res_status_nxt = ogu_pkg::ST_OUTSIDE;
        endcase
      end
      ogu_pkg::B_INFL: begin
        // the center already holds full, so it is skipped
        mem_re    = off_ok && !((dr_r == OFF_LAST >> 1) && (dc_r == OFF_LAST >> 1));
        mem_raddr = {nr[ogu_pkg::ROW_W-1:0], nc[ogu_pkg::COL_W-1:0]};
        pv_nxt    = mem_re;
        pa_nxt    = mem_raddr;
        if (dc_r == OFF_LAST) begin
          dc_nxt = '0;
          dr_nxt = dr_r + 1'b1;
        end else begin
          dc_nxt = dc_r + 1'b1;
        end
      end
      ogu_pkg::B_DECAY: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_r;
        pv_nxt    = 1'b1;
        pa_nxt    = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
      end
      ogu_pkg::B_RDWAIT: res_value_nxt = rd_data_r;
      ogu_pkg::B_DONE:   out_load = out_free;
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ogu_pkg::B_CLEAR;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    dr_r         <= dr_nxt;
    dc_r         <= dc_nxt;
    pa_r         <= pa_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_col_r    <= res_col_nxt;
    res_row_r    <= res_row_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_col_r    <= res_col_r;
      out_row_r    <= res_row_r;
    end
  end

  // grid memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cell_value = out_value_r;
  assign out_cell_col   = out_col_r;
  assign out_cell_row   = out_row_r;

  `OGU_ASSERT_IMPL(a_no_pop_in_clear, state_r == ogu_pkg::B_CLEAR, !q_pop)
  `OGU_ASSERT_IMPL(a_load_when_free, out_load, !out_valid_r || out_ready)
  `OGU_ASSERT_IMPL(a_pend_in_scan, pv_r, in_scan)
  `OGU_ASSERT_NEXT(a_drain_empties, state_r == ogu_pkg::B_DRAIN, !pv_r)

endmodule
